FILE: rtl/priority_round_robin_dispatcher_defines.svh
// assertion macros for the priority round robin dispatcher
`ifndef PRIORITY_ROUND_ROBIN_DISPATCHER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_DISPATCHER_DEFINES_SVH

`ifndef SYNTH
// clocked check, quiet while reset is high
`define PRRD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dispatcher check failed");
// clocked check that also holds during reset
`define PRRD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("dispatcher check failed");
`else
`define PRRD_ASSERT(lbl, clk, rst, prop)
`define PRRD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/prrd_pkg.sv
// shared types and constants of the priority round robin dispatcher
package prrd_pkg;

   localparam int ID_W     = 8;
   localparam int PRI_W    = 4;
   localparam int TIME_W   = 16;
   localparam int STATUS_W = 2;

   localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd10;

   // operation codes
   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SLICE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IDLE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // one task table word
   typedef struct packed {
      logic [PRI_W-1:0]  pri;
      logic [TIME_W-1:0] remaining;
      logic [ID_W-1:0]   ident;
   } entry_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic             clear;
      logic             sample;
      logic             have_last;
      logic [PRI_W-1:0] last_level;
   } scan_ctl_type;

   // chosen candidate of a finished scan
   typedef struct packed {
      logic             found;
      logic [PRI_W-1:0] level;
      entry_type        word;
   } cand_type;

endpackage

FILE: rtl/prrd_req_if.sv
// request channel: add or dispatch items
interface prrd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [prrd_pkg::ID_W-1:0]   task_id;
   logic [prrd_pkg::PRI_W-1:0]  priority_req;
   logic [prrd_pkg::TIME_W-1:0] burst;

   modport source (output valid, operation, task_id, priority_req, burst, input ready);
   modport sink   (input valid, operation, task_id, priority_req, burst, output ready);
endinterface

FILE: rtl/prrd_rsp_if.sv
// response channel: one result per request
interface prrd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [prrd_pkg::STATUS_W-1:0] status;
   logic [prrd_pkg::ID_W-1:0]     run_id;
   logic [prrd_pkg::PRI_W-1:0]    run_priority;
   logic [prrd_pkg::TIME_W-1:0]   slice;
   logic                         finished;

   modport source (output valid, status, run_id, run_priority, slice, finished,
                   input ready);
   modport sink   (input valid, status, run_id, run_priority, slice, finished,
                   output ready);
endinterface

FILE: rtl/prrd_ram.sv
// generic single port ram with registered read
module prrd_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one word per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/prrd_scan.sv
// scan unit: tracks top level and round robin candidates over the table read stream
module prrd_scan #(
   parameter int SLOT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  prrd_pkg::scan_ctl_type ctl,
   input  logic [SLOT_W-1:0]      slot,
   input  logic [SLOT_W-1:0]      last_slot,
   input  prrd_pkg::entry_type    word,
   output prrd_pkg::cand_type     cand,
   output logic [SLOT_W-1:0]      pick_slot
);

   logic                       found_ff, found_in;
   logic [prrd_pkg::PRI_W-1:0] level_ff, level_in;
   logic [SLOT_W-1:0]          first_slot_ff, first_slot_in;
   prrd_pkg::entry_type        first_word_ff, first_word_in;
   logic                       after_ok_ff, after_ok_in;
   logic [SLOT_W-1:0]          after_slot_ff, after_slot_in;
   prrd_pkg::entry_type        after_word_ff, after_word_in;
   logic                       use_after;

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         after_ok_ff <= 1'b0;
      end else begin
         found_ff    <= found_in;
         after_ok_ff <= after_ok_in;
      end
   end

   // candidate payload
   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      first_slot_ff <= first_slot_in;
      first_word_ff <= first_word_in;
      after_slot_ff <= after_slot_in;
      after_word_ff <= after_word_in;
   end

   // a higher level restarts both candidates, same level only fills the one after last
   always_comb begin
      found_in      = found_ff;
      level_in      = level_ff;
      first_slot_in = first_slot_ff;
      first_word_in = first_word_ff;
      after_ok_in   = after_ok_ff;
      after_slot_in = after_slot_ff;
      after_word_in = after_word_ff;
      if (ctl.clear) begin
         found_in    = 1'b0;
         after_ok_in = 1'b0;
      end else if (ctl.sample) begin
         if (!found_ff || word.pri > level_ff) begin
            found_in      = 1'b1;
            level_in      = word.pri;
            first_slot_in = slot;
            first_word_in = word;
            after_ok_in   = slot > last_slot;
            after_slot_in = slot;
            after_word_in = word;
         end else if (word.pri == level_ff && !after_ok_ff && slot > last_slot) begin
            after_ok_in   = 1'b1;
            after_slot_in = slot;
            after_word_in = word;
         end
      end
   end

   // resume after last slot on the same level, otherwise lowest slot (also the wrap)
   assign use_after  = ctl.have_last && ctl.last_level == level_ff && after_ok_ff;
   assign cand.found = found_ff;
   assign cand.level = level_ff;
   assign cand.word  = use_after ? after_word_ff : first_word_ff;
   assign pick_slot  = use_after ? after_slot_ff : first_slot_ff;

endmodule

FILE: rtl/priority_round_robin_dispatcher.sv
// priority round robin dispatcher top level
//
//   channel  direction  transfer
//   req_ch   in         add task or dispatch request
//   rsp_ch   out        status, run id, priority, slice, finished
//   csr_*    in         quantum write, no read-back
//
// an add goes from idle straight to the commit state, which writes the table
// a dispatch reads the task table ram one slot a cycle over the single port,
// then a drain state lets the last read land and a commit state writes back
// reset clears the valid bits and pointers at once; no clearing pass
// a result waiting on rsp_ch does not stop a new request transfer; only the
// write-back cycle waits for the output register to free up
`include "priority_round_robin_dispatcher_defines.svh"

module priority_round_robin_dispatcher #(
   parameter int TASKS  = 16,
   parameter int LEVELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   prrd_req_if.sink                      req_ch,
   prrd_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [prrd_pkg::TIME_W-1:0]   csr_wr_data
);

   localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W  = $clog2(TASKS + 1);

   prrd_pkg::state_type          state_ff, state_in;
   logic                         op_ff, op_in;
   logic [prrd_pkg::ID_W-1:0]    id_ff, id_in;
   logic [prrd_pkg::PRI_W-1:0]   pri_ff, pri_in;
   logic [prrd_pkg::TIME_W-1:0]  burst_ff, burst_in;
   logic [SLOT_W-1:0]            scan_ff, scan_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]            rd_slot_ff, rd_slot_in;
   logic [TASKS-1:0]             valid_ff, valid_in;
   logic [CNT_W-1:0]             append_ff, append_in;
   logic [SLOT_W-1:0]            last_slot_ff, last_slot_in;
   logic [prrd_pkg::PRI_W-1:0]   last_level_ff, last_level_in;
   logic                         have_last_ff, have_last_in;
   logic [prrd_pkg::TIME_W-1:0]  quantum_ff, quantum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [prrd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [prrd_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [prrd_pkg::PRI_W-1:0]   rsp_pri_ff, rsp_pri_in;
   logic [prrd_pkg::TIME_W-1:0]  rsp_slice_ff, rsp_slice_in;
   logic                         rsp_fin_ff, rsp_fin_in;

   logic                         ram_we;
   logic [SLOT_W-1:0]            ram_addr;
   prrd_pkg::entry_type          ram_wdata, ram_rdata;
   prrd_pkg::scan_ctl_type       scan_ctl;
   prrd_pkg::cand_type           cand;
   logic [SLOT_W-1:0]            pick_slot;

   logic                         req_xfer;
   logic                         out_free;
   logic [prrd_pkg::PRI_W-1:0]   pri_sat;
   logic [prrd_pkg::TIME_W-1:0]  q_eff;
   logic [prrd_pkg::TIME_W-1:0]  slice_len;
   logic [prrd_pkg::TIME_W-1:0]  rem_left;
   logic [TASKS-1:0]             valid_cleared;

   // task table
   prrd_ram #(
      .WIDTH ($bits(prrd_pkg::entry_type)),
      .DEPTH (TASKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // level and round robin candidate tracking
   prrd_scan #(
      .SLOT_W (SLOT_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .slot      (rd_slot_ff),
      .last_slot (last_slot_ff),
      .word      (ram_rdata),
      .cand      (cand),
      .pick_slot (pick_slot)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prrd_pkg::ST_IDLE;
         rd_pend_ff    <= 1'b0;
         valid_ff      <= '0;
         append_ff     <= '0;
         last_slot_ff  <= '0;
         last_level_ff <= '0;
         have_last_ff  <= 1'b0;
         quantum_ff    <= prrd_pkg::QUANTUM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         valid_ff      <= valid_in;
         append_ff     <= append_in;
         last_slot_ff  <= last_slot_in;
         last_level_ff <= last_level_in;
         have_last_ff  <= have_last_in;
         quantum_ff    <= quantum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      pri_ff        <= pri_in;
      burst_ff      <= burst_in;
      scan_ff       <= scan_in;
      rd_slot_ff    <= rd_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   // request transfer and priority saturation
   assign req_ch.ready = (state_ff == prrd_pkg::ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign pri_sat      = (32'(req_ch.priority_req) > LEVELS - 1)
                         ? prrd_pkg::PRI_W'(LEVELS - 1) : req_ch.priority_req;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // slice arithmetic on the chosen entry
   assign q_eff         = (quantum_ff == '0) ? prrd_pkg::TIME_W'(1) : quantum_ff;
   assign slice_len     = (cand.word.remaining > q_eff) ? q_eff : cand.word.remaining;
   assign rem_left      = cand.word.remaining - slice_len;
   assign valid_cleared = valid_ff & ~(TASKS'(1) << pick_slot);

   // scan unit control
   assign scan_ctl.clear      = req_xfer;
   assign scan_ctl.sample     = rd_pend_ff;
   assign scan_ctl.have_last  = have_last_ff;
   assign scan_ctl.last_level = last_level_ff;

   // sequencer: next state, table access, write-back and result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      pri_in        = pri_ff;
      burst_in      = burst_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_slot_in    = rd_slot_ff;
      valid_in      = valid_ff;
      append_in     = append_ff;
      last_slot_in  = last_slot_ff;
      last_level_in = last_level_ff;
      have_last_in  = have_last_ff;
      quantum_in    = csr_wr_en ? csr_wr_data : quantum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_slice_in  = rsp_slice_ff;
      rsp_fin_in    = rsp_fin_ff;
      ram_we        = 1'b0;
      ram_addr      = scan_ff;
      ram_wdata     = '0;

      case (state_ff)
         prrd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               op_in    = req_ch.operation;
               id_in    = req_ch.task_id;
               pri_in   = pri_sat;
               burst_in = req_ch.burst;
               scan_in  = '0;
               state_in = (req_ch.operation == prrd_pkg::OP_DISPATCH)
                          ? prrd_pkg::ST_SCAN : prrd_pkg::ST_COMMIT;
            end
         end
         prrd_pkg::ST_SCAN: begin
            // one slot read a cycle, liveness travels with the read
            ram_addr   = scan_ff;
            rd_pend_in = valid_ff[scan_ff];
            rd_slot_in = scan_ff;
            if (scan_ff == SLOT_W'(TASKS - 1)) begin
               state_in = prrd_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end
         prrd_pkg::ST_DRAIN: begin
            state_in = prrd_pkg::ST_COMMIT;
         end
         prrd_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in      = prrd_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_pri_in    = '0;
               rsp_slice_in  = '0;
               rsp_fin_in    = 1'b0;
               if (op_ff == prrd_pkg::OP_ADD) begin
                  if (append_ff >= CNT_W'(TASKS)) begin
                     rsp_status_in = prrd_pkg::STATUS_FULL;
                  end else begin
                     ram_we          = 1'b1;
                     ram_addr        = append_ff[SLOT_W-1:0];
                     ram_wdata.pri   = pri_ff;
                     ram_wdata.remaining = burst_ff;
                     ram_wdata.ident = id_ff;
                     valid_in        = valid_ff | (TASKS'(1) << append_ff[SLOT_W-1:0]);
                     append_in       = append_ff + CNT_W'(1);
                     rsp_status_in   = prrd_pkg::STATUS_ADDED;
                  end
               end else if (!cand.found) begin
                  rsp_status_in = prrd_pkg::STATUS_IDLE;
               end else begin
                  ram_we              = 1'b1;
                  ram_addr            = pick_slot;
                  ram_wdata           = cand.word;
                  ram_wdata.remaining = rem_left;
                  if (rem_left == '0) begin
                     valid_in = valid_cleared;
                     if (valid_cleared == '0) begin
                        append_in = '0;
                     end
                  end
                  last_slot_in  = pick_slot;
                  last_level_in = cand.level;
                  have_last_in  = 1'b1;
                  rsp_status_in = prrd_pkg::STATUS_SLICE;
                  rsp_id_in     = cand.word.ident;
                  rsp_pri_in    = cand.word.pri;
                  rsp_slice_in  = slice_len;
                  rsp_fin_in    = (rem_left == '0);
               end
            end
         end
         default: begin
            state_in = prrd_pkg::ST_IDLE;
         end
      endcase
   end

   // result register
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.run_id       = rsp_id_ff;
   assign rsp_ch.run_priority = rsp_pri_ff;
   assign rsp_ch.slice        = rsp_slice_ff;
   assign rsp_ch.finished     = rsp_fin_ff;

   // checks
   `PRRD_ASSERT(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == prrd_pkg::ST_COMMIT))
   `PRRD_ASSERT(a_append_bound, clock, reset, append_ff <= CNT_W'(TASKS))
   `PRRD_ASSERT(a_empty_rewinds, clock, reset, (valid_ff == '0) |-> (append_ff == '0))
   `PRRD_ASSERT(a_no_valid_above_append, clock, reset, ((valid_ff >> append_ff) == '0))
   `PRRD_ASSERT(a_pick_is_live, clock, reset, (state_ff == prrd_pkg::ST_COMMIT && op_ff == prrd_pkg::OP_DISPATCH && cand.found) |-> valid_ff[pick_slot])

endmodule

FILE: bench/dispatcher_checker.sv
`timescale 1ns / 100ps
// checker: predicts each dispatcher result from observed transfers and compares them
module dispatcher_checker #(
   parameter int TASKS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   prrd_req_if                         req_ch,
   prrd_rsp_if                         rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [prrd_pkg::TIME_W-1:0] csr_wr_data,
   output int                          error_count,
   output int                          pending
);

   // one result as the block should return it
   typedef struct packed {
      logic [prrd_pkg::STATUS_W-1:0] status;
      logic [prrd_pkg::ID_W-1:0]     run_id;
      logic [prrd_pkg::PRI_W-1:0]    run_priority;
      logic [prrd_pkg::TIME_W-1:0]   slice;
      logic                          finished;
   } outcome_type;

   // shadow task table and round robin pointers
   logic                        slot_live  [TASKS];
   logic [prrd_pkg::PRI_W-1:0]  slot_level [TASKS];
   logic [prrd_pkg::TIME_W-1:0] slot_left  [TASKS];
   logic [prrd_pkg::ID_W-1:0]   slot_ident [TASKS];
   int                          append_slot;
   int                          last_slot;
   logic [prrd_pkg::PRI_W-1:0]  last_level;
   logic                        have_last;
   logic [prrd_pkg::TIME_W-1:0] quantum;

   outcome_type expected_outcomes [$];
   int          fail_total = 0;
   int          waiting = 0;

   assign error_count = fail_total;
   assign pending     = waiting;

   // apply one request to the shadow table and return its result
   function automatic outcome_type schedule_item(input logic op,
                                                 input logic [prrd_pkg::ID_W-1:0] id,
                                                 input logic [prrd_pkg::PRI_W-1:0] pri,
                                                 input logic [prrd_pkg::TIME_W-1:0] burst);
      outcome_type                 res;
      logic                        any;
      logic                        got;
      logic                        left;
      logic [prrd_pkg::PRI_W-1:0]  level;
      logic [prrd_pkg::TIME_W-1:0] q;
      logic [prrd_pkg::TIME_W-1:0] sl;
      int                          start;
      int                          pick;
      int                          s;
      res = '0;
      if (op == prrd_pkg::OP_ADD) begin
         if (append_slot >= TASKS) begin
            res.status = prrd_pkg::STATUS_FULL;
         end else begin
            slot_live[append_slot]  = 1'b1;
            slot_ident[append_slot] = id;
            slot_level[append_slot] = pri;
            slot_left[append_slot]  = burst;
            append_slot++;
            res.status = prrd_pkg::STATUS_ADDED;
         end
         return res;
      end
      // highest level that still holds a live task
      any   = 1'b0;
      level = '0;
      for (int i = 0; i < TASKS; i++) begin
         if (slot_live[i] && (!any || slot_level[i] > level)) begin
            level = slot_level[i];
            any   = 1'b1;
         end
      end
      if (!any) begin
         res.status = prrd_pkg::STATUS_IDLE;
         return res;
      end
      // resume after the last slot on the same level, else from the bottom
      start = (have_last && last_level == level) ? (last_slot + 1) % TASKS : 0;
      pick  = 0;
      got   = 1'b0;
      for (int k = 0; k < TASKS; k++) begin
         s = (start + k) % TASKS;
         if (!got && slot_live[s] && slot_level[s] == level) begin
            pick = s;
            got  = 1'b1;
         end
      end
      q  = (quantum == '0) ? prrd_pkg::TIME_W'(1) : quantum;
      sl = (slot_left[pick] > q) ? q : slot_left[pick];
      slot_left[pick] = slot_left[pick] - sl;
      if (slot_left[pick] == '0) begin
         slot_live[pick] = 1'b0;
         res.finished    = 1'b1;
         left = 1'b0;
         for (int i = 0; i < TASKS; i++) begin
            if (slot_live[i]) begin
               left = 1'b1;
            end
         end
         // empty table restarts the append pointer
         if (!left) begin
            append_slot = 0;
         end
      end
      last_slot  = pick;
      last_level = level;
      have_last  = 1'b1;
      res.status       = prrd_pkg::STATUS_SLICE;
      res.run_id       = slot_ident[pick];
      res.run_priority = slot_level[pick];
      res.slice        = sl;
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         fail_total++;
         $error("%s: expected %0d, actual %0d", name, want, seen);
      end
   endtask

   // watch request, result and register transfers
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < TASKS; i++) begin
            slot_live[i] = 1'b0;
         end
         append_slot = 0;
         last_slot   = 0;
         last_level  = '0;
         have_last   = 1'b0;
         quantum     = prrd_pkg::QUANTUM_RESET;
         expected_outcomes.delete();
      end else begin
         if (csr_wr_en) begin
            quantum = csr_wr_data;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_outcomes.push_back(schedule_item(req_ch.operation, req_ch.task_id,
                                                      req_ch.priority_req, req_ch.burst));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
               fail_total++;
               $error("unexpected result transfer: status %0d", rsp_ch.status);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", int'(want.status), int'(rsp_ch.status));
               check_field("run_id", int'(want.run_id), int'(rsp_ch.run_id));
               check_field("run_priority", int'(want.run_priority),
                           int'(rsp_ch.run_priority));
               check_field("slice", int'(want.slice), int'(rsp_ch.slice));
               check_field("finished", int'(want.finished), int'(rsp_ch.finished));
            end
         end
      end
      waiting = expected_outcomes.size();
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench top: drives requests and quantum writes into the dispatcher and gives the verdict
module testbench;

   localparam int TASKS       = 16;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en;
   logic [prrd_pkg::TIME_W-1:0] csr_wr_data;
   int                          error_count;
   int                          pending;
   int                          cycle_count = 0;

   // sender and receiver idling controls
   int                          burst_left = 0;
   int                          gap_max = 0;
   int                          stall_max = 0;
   int                          ready_left = 0;
   logic [prrd_pkg::TIME_W-1:0] cur_quantum = prrd_pkg::QUANTUM_RESET;

   prrd_req_if req_ch ();
   prrd_rsp_if rsp_ch ();

   priority_round_robin_dispatcher #(
      .TASKS (TASKS),
      .LEVELS(16)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   dispatcher_checker #(
      .TASKS(TASKS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .error_count(error_count),
      .pending    (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // receiver: alternating ready and stall stretches, always ready while stall_max is zero
   always @(negedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if (rsp_ch.ready && stall_max > 0) begin
         rsp_ch.ready <= 1'b0;
         ready_left = $urandom_range(stall_max, 1) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         ready_left = $urandom_range(24, 1) - 1;
      end
   end

   // one request transfer, entered and left just after a rising edge
   task automatic send_item(input logic op, input logic [prrd_pkg::ID_W-1:0] id,
                            input logic [prrd_pkg::PRI_W-1:0] pri,
                            input logic [prrd_pkg::TIME_W-1:0] burst);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap        = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
         burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.task_id      <= id;
      req_ch.priority_req <= pri;
      req_ch.burst        <= burst;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_quantum(input logic [prrd_pkg::TIME_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_quantum = value;
   endtask

   // random traffic in fill, drain and mixed stretches
   task automatic random_phase(input int count);
      int                          chunk;
      int                          add_pct;
      logic                        op;
      logic [prrd_pkg::PRI_W-1:0]  pri;
      logic [prrd_pkg::TIME_W-1:0] burst;
      chunk   = 0;
      add_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (chunk == 0) begin
            chunk = $urandom_range(40, 8);
            case ($urandom_range(2, 0))
               0:       add_pct = 75;
               1:       add_pct = 20;
               default: add_pct = 50;
            endcase
         end
         chunk--;
         op = ($urandom_range(99, 0) < add_pct) ? prrd_pkg::OP_ADD : prrd_pkg::OP_DISPATCH;
         // half full range, half a few shared levels so round robin kicks in
         if ($urandom_range(1, 0) == 0) begin
            pri = prrd_pkg::PRI_W'($urandom_range(15, 0));
         end else begin
            pri = prrd_pkg::PRI_W'($urandom_range(2, 0) * 6 + 3);
         end
         // long bursts only while the quantum is at least 1024
         if (cur_quantum >= 16'd1024 && $urandom_range(9, 0) == 0) begin
            burst = prrd_pkg::TIME_W'($urandom);
         end else if ($urandom_range(19, 0) == 0) begin
            burst = '0;
         end else begin
            burst = prrd_pkg::TIME_W'($urandom_range(40, 1));
         end
         send_item(op, prrd_pkg::ID_W'($urandom), pri, burst);
      end
   endtask

   initial begin
      logic [prrd_pkg::TIME_W-1:0] qv;
      req_ch.valid        = 1'b0;
      req_ch.operation    = prrd_pkg::OP_ADD;
      req_ch.task_id      = '0;
      req_ch.priority_req = '0;
      req_ch.burst        = '0;
      rsp_ch.ready        = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, field extremes, zero burst, table full
      gap_max   = 2;
      stall_max = 6;
      send_item(prrd_pkg::OP_DISPATCH, 8'h00, 4'h0, 16'h0000);
      send_item(prrd_pkg::OP_ADD, 8'h00, 4'h0, 16'h0000);
      send_item(prrd_pkg::OP_ADD, 8'hFF, 4'hF, 16'hFFFF);
      send_item(prrd_pkg::OP_ADD, 8'h5A, 4'hF, 16'h0000);
      send_item(prrd_pkg::OP_ADD, 8'hA5, 4'hF, 16'h0003);
      for (int i = 4; i < TASKS; i++) begin
         send_item(prrd_pkg::OP_ADD, prrd_pkg::ID_W'(i * 17), prrd_pkg::PRI_W'(i % 3 + 7),
                   prrd_pkg::TIME_W'(i + 5));
      end
      send_item(prrd_pkg::OP_ADD, 8'h77, 4'h8, 16'h0001);
      repeat (6) send_item(prrd_pkg::OP_DISPATCH, 8'h00, 4'h0, 16'h0000);

      // random phases over several quantum settings and idling mixes
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       qv = 16'hFFFF;
            1:       qv = 16'd1;
            2:       qv = 16'd0;
            3:       qv = 16'd7;
            4:       qv = prrd_pkg::TIME_W'($urandom_range(65535, 1024));
            default: qv = prrd_pkg::QUANTUM_RESET;
         endcase
         write_quantum(qv);
         gap_max   = (p % 3 == 0) ? 0 : p * 2;
         stall_max = (p % 2 == 0) ? 20 : ((p == 1) ? 0 : 5);
         random_phase(300);
      end

      wait_drained();
      repeat (TASKS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
